/* rtl/cau_pkg.sv */
// Shared types for the complex arithmetic unit.
// No dependencies; imported by every cau module.
package cau_pkg;

	localparam int DATA_WIDTH_DEF = 16;
	localparam int FRAC_BITS_DEF  = 8;

	typedef enum logic [2:0] {
		MODE_EQ  = 3'd0,
		MODE_ADD = 3'd1,
		MODE_SUB = 3'd2,
		MODE_MUL = 3'd3,
		MODE_DIV = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_SAT  = 2'd1,
		ST_DIV0 = 2'd2
	} status_t;

	// per-word control carried alongside the divider
	typedef struct packed {
		logic [2:0] mode;
		logic       eq;
		logic       sat;
		logic       neg_re;
		logic       neg_im;
		logic       dz;
	} flags_t;

endpackage

/* rtl/cau_mult.sv */
// Stage 1: operand products, sums, differences and equality.
// Depends on cau_pkg.
module cau_mult #(
	parameter int W = cau_pkg::DATA_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2:0]            mode,
	input  logic signed [W-1:0]   a_real,
	input  logic signed [W-1:0]   a_imag,
	input  logic signed [W-1:0]   b_real,
	input  logic signed [W-1:0]   b_imag,
	output logic [2:0]            mode_s1,
	output logic                  eq_s1,
	output logic signed [W:0]     add_re_s1,
	output logic signed [W:0]     add_im_s1,
	output logic signed [W:0]     sub_re_s1,
	output logic signed [W:0]     sub_im_s1,
	output logic signed [2*W-1:0] p_rr_s1,
	output logic signed [2*W-1:0] p_ii_s1,
	output logic signed [2*W-1:0] p_ir_s1,
	output logic signed [2*W-1:0] p_ri_s1,
	output logic signed [2*W-1:0] p_bb_s1,
	output logic signed [2*W-1:0] p_cc_s1
);
	import cau_pkg::*;

	localparam int SW = W + 1;

	always_ff @(posedge clk) begin
		if (en) begin
			mode_s1   <= mode;
			eq_s1     <= (a_real == b_real) && (a_imag == b_imag);
			add_re_s1 <= SW'(a_real) + SW'(b_real);
			add_im_s1 <= SW'(a_imag) + SW'(b_imag);
			sub_re_s1 <= SW'(a_real) - SW'(b_real);
			sub_im_s1 <= SW'(a_imag) - SW'(b_imag);
			p_rr_s1   <= a_real * b_real;
			p_ii_s1   <= a_imag * b_imag;
			p_ir_s1   <= a_imag * b_real;
			p_ri_s1   <= a_real * b_imag;
			p_bb_s1   <= b_real * b_real;
			p_cc_s1   <= b_imag * b_imag;
		end
	end

endmodule

/* rtl/cau_prep.sv */
// Stage 2: saturated add, subtract and product results, divide numerators and divisor.
// Depends on cau_pkg.
module cau_prep #(
	parameter int W = cau_pkg::DATA_WIDTH_DEF,
	parameter int F = cau_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic [2:0]            mode_s1,
	input  logic                  eq_s1,
	input  logic signed [W:0]     add_re_s1,
	input  logic signed [W:0]     add_im_s1,
	input  logic signed [W:0]     sub_re_s1,
	input  logic signed [W:0]     sub_im_s1,
	input  logic signed [2*W-1:0] p_rr_s1,
	input  logic signed [2*W-1:0] p_ii_s1,
	input  logic signed [2*W-1:0] p_ir_s1,
	input  logic signed [2*W-1:0] p_ri_s1,
	input  logic signed [2*W-1:0] p_bb_s1,
	input  logic signed [2*W-1:0] p_cc_s1,
	output cau_pkg::flags_t       flg_s2,
	output logic [W-1:0]          re_s2,
	output logic [W-1:0]          im_s2,
	output logic [2*W-1:0]        mag_re_s2,
	output logic [2*W-1:0]        mag_im_s2,
	output logic [2*W-1:0]        den_s2
);
	import cau_pkg::*;

	localparam int PW = 2 * W + 1;

	logic signed [PW-1:0] mr, mi, dr, di, mr_sh, mi_sh;
	logic signed [PW-1:0] dr_neg, di_neg;
	logic [2*W-1:0]       den;
	logic signed [W:0]    sr, si;
	logic [W-1:0]         rr, ri;
	logic                 ovr, ovi;
	logic                 ovr_w, ovi_w;
	logic [W-1:0]         rr_w, ri_w;
	mode_t                md;

	always_comb begin
		md     = mode_t'(mode_s1);
		mr     = PW'(p_rr_s1) - PW'(p_ii_s1);
		mi     = PW'(p_ir_s1) + PW'(p_ri_s1);
		mr_sh  = mr >>> F;
		mi_sh  = mi >>> F;
		dr     = PW'(p_rr_s1) + PW'(p_ii_s1);
		di     = PW'(p_ir_s1) - PW'(p_ri_s1);
		dr_neg = -dr;
		di_neg = -di;
		den    = p_bb_s1[2*W-1:0] + p_cc_s1[2*W-1:0];

		// wide product results
		ovr_w = !((&mr_sh[PW-1:W-1]) || !(|mr_sh[PW-1:W-1]));
		ovi_w = !((&mi_sh[PW-1:W-1]) || !(|mi_sh[PW-1:W-1]));
		rr_w  = ovr_w ? {mr_sh[PW-1], {(W-1){~mr_sh[PW-1]}}} : mr_sh[W-1:0];
		ri_w  = ovi_w ? {mi_sh[PW-1], {(W-1){~mi_sh[PW-1]}}} : mi_sh[W-1:0];

		sr = (md == MODE_SUB) ? sub_re_s1 : add_re_s1;
		si = (md == MODE_SUB) ? sub_im_s1 : add_im_s1;
		unique case (md)
			MODE_ADD, MODE_SUB: begin
				ovr = sr[W] != sr[W-1];
				ovi = si[W] != si[W-1];
				rr  = ovr ? {sr[W], {(W-1){~sr[W]}}} : sr[W-1:0];
				ri  = ovi ? {si[W], {(W-1){~si[W]}}} : si[W-1:0];
			end
			MODE_MUL: begin
				ovr = ovr_w;
				ovi = ovi_w;
				rr  = rr_w;
				ri  = ri_w;
			end
			default: begin
				ovr = 1'b0;
				ovi = 1'b0;
				rr  = '0;
				ri  = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s2.mode   <= mode_s1;
			flg_s2.eq     <= (md == MODE_EQ) && eq_s1;
			flg_s2.sat    <= ovr || ovi;
			flg_s2.neg_re <= dr[PW-1];
			flg_s2.neg_im <= di[PW-1];
			flg_s2.dz     <= (den == '0);
			re_s2         <= rr;
			im_s2         <= ri;
			mag_re_s2     <= dr[PW-1] ? dr_neg[2*W-1:0] : dr[2*W-1:0];
			mag_im_s2     <= di[PW-1] ? di_neg[2*W-1:0] : di[2*W-1:0];
			den_s2        <= den;
		end
	end

endmodule

/* rtl/cau_divider.sv */
// Pipelined restoring divider: floor(mag * 2^F / den), one quotient bit per stage.
// First stage flags quotients of 2^W or more. Depends on cau_pkg.
module cau_divider #(
	parameter int W = cau_pkg::DATA_WIDTH_DEF,
	parameter int F = cau_pkg::FRAC_BITS_DEF
) (
	input  logic           clk,
	input  logic           en,
	input  logic [2*W-1:0] mag,
	input  logic [2*W-1:0] den,
	output logic [W-1:0]   quot,
	output logic           ovf
);
	import cau_pkg::*;

	localparam int NW = 2 * W + F;
	localparam int XW = 3 * W + F;

	logic [NW-1:0]  r_s3   [0:W];
	logic [2*W-1:0] den_s3 [0:W];
	logic [W-1:0]   q_s3   [0:W];
	logic           ovf_s3 [0:W];

	always_ff @(posedge clk) begin
		if (en) begin
			r_s3[0]   <= NW'(mag) << F;
			den_s3[0] <= den;
			q_s3[0]   <= '0;
			ovf_s3[0] <= (XW'(mag) << F) >= (XW'(den) << W);
		end
	end

	for (genvar s = 1; s <= W; s++) begin : g_step
		localparam int SH = W - s;
		logic [XW-1:0] dsh;
		logic          take;
		assign dsh  = XW'(den_s3[s-1]) << SH;
		assign take = XW'(r_s3[s-1]) >= dsh;
		always_ff @(posedge clk) begin
			if (en) begin
				r_s3[s]   <= take ? NW'(XW'(r_s3[s-1]) - dsh) : r_s3[s-1];
				den_s3[s] <= den_s3[s-1];
				q_s3[s]   <= q_s3[s-1] | (take ? (W'(1) << SH) : '0);
				ovf_s3[s] <= ovf_s3[s-1];
			end
		end
	end

	assign quot = q_s3[W];
	assign ovf  = ovf_s3[W];

endmodule

/* rtl/complex_arithmetic_unit.sv */
// Complex arithmetic unit: equality, add, subtract, multiply, divide on Q-format operands.
// Every mode passes through the same pipeline: one product
// stage, one prep stage, DATA_WIDTH + 1 divider stages and the output register.
// Throughput one word per cycle; the whole pipeline holds while the output is stalled.
// arst_n clears all valid bits; data registers are not reset.
// Uses cau_pkg, cau_mult, cau_prep and cau_divider.
module complex_arithmetic_unit #(
	parameter int DATA_WIDTH = cau_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS  = cau_pkg::FRAC_BITS_DEF,
	localparam int IN_W  = ((3 + 4 * DATA_WIDTH + 7) / 8) * 8,
	localparam int OUT_W = ((2 * DATA_WIDTH + 3 + 7) / 8) * 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,  // mode, a_real, a_imag, b_real, b_imag
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata   // result_real, result_imag, is_equal, status
);
	import cau_pkg::*;

	localparam int W = DATA_WIDTH;

	logic en;
	logic v_s1, v_s2;
	logic v_s3 [0:W];
	logic v_s4;

	logic [2:0]            mode_s1;
	logic                  eq_s1;
	logic signed [W:0]     add_re_s1, add_im_s1, sub_re_s1, sub_im_s1;
	logic signed [2*W-1:0] p_rr_s1, p_ii_s1, p_ir_s1, p_ri_s1, p_bb_s1, p_cc_s1;

	flags_t         flg_s2;
	logic [W-1:0]   re_s2, im_s2;
	logic [2*W-1:0] mag_re_s2, mag_im_s2, den_s2;

	flags_t       flg_s3 [0:W];
	logic [W-1:0] re_s3  [0:W];
	logic [W-1:0] im_s3  [0:W];

	logic [W-1:0] q_re, q_im;
	logic         ovf_re, ovf_im;

	logic [W-1:0] res_re_s4, res_im_s4;
	logic         eq_s4;
	status_t      st_s4;

	logic [W-1:0] dre, dim, fre, fim;
	logic         sre, sim;
	status_t      st;
	flags_t       fl;

	assign en       = !v_s4 || m_tready;
	assign s_tready = en;
	assign m_tvalid = v_s4;

	cau_mult #(.W(W)) u_mult (
		.clk      (clk),
		.en       (en),
		.mode     (s_tdata[2:0]),
		.a_real   (s_tdata[3 +: W]),
		.a_imag   (s_tdata[3 + W +: W]),
		.b_real   (s_tdata[3 + 2 * W +: W]),
		.b_imag   (s_tdata[3 + 3 * W +: W]),
		.mode_s1  (mode_s1),
		.eq_s1    (eq_s1),
		.add_re_s1(add_re_s1),
		.add_im_s1(add_im_s1),
		.sub_re_s1(sub_re_s1),
		.sub_im_s1(sub_im_s1),
		.p_rr_s1  (p_rr_s1),
		.p_ii_s1  (p_ii_s1),
		.p_ir_s1  (p_ir_s1),
		.p_ri_s1  (p_ri_s1),
		.p_bb_s1  (p_bb_s1),
		.p_cc_s1  (p_cc_s1)
	);

	cau_prep #(.W(W), .F(FRAC_BITS)) u_prep (
		.clk      (clk),
		.en       (en),
		.mode_s1  (mode_s1),
		.eq_s1    (eq_s1),
		.add_re_s1(add_re_s1),
		.add_im_s1(add_im_s1),
		.sub_re_s1(sub_re_s1),
		.sub_im_s1(sub_im_s1),
		.p_rr_s1  (p_rr_s1),
		.p_ii_s1  (p_ii_s1),
		.p_ir_s1  (p_ir_s1),
		.p_ri_s1  (p_ri_s1),
		.p_bb_s1  (p_bb_s1),
		.p_cc_s1  (p_cc_s1),
		.flg_s2   (flg_s2),
		.re_s2    (re_s2),
		.im_s2    (im_s2),
		.mag_re_s2(mag_re_s2),
		.mag_im_s2(mag_im_s2),
		.den_s2   (den_s2)
	);

	cau_divider #(.W(W), .F(FRAC_BITS)) u_div_re (
		.clk (clk),
		.en  (en),
		.mag (mag_re_s2),
		.den (den_s2),
		.quot(q_re),
		.ovf (ovf_re)
	);

	cau_divider #(.W(W), .F(FRAC_BITS)) u_div_im (
		.clk (clk),
		.en  (en),
		.mag (mag_im_s2),
		.den (den_s2),
		.quot(q_im),
		.ovf (ovf_im)
	);

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= s_tvalid;
			v_s2 <= v_s1;
			v_s4 <= v_s3[W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3[0] <= 1'b0;
		end else if (en) begin
			v_s3[0] <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			flg_s3[0] <= flg_s2;
			re_s3[0]  <= re_s2;
			im_s3[0]  <= im_s2;
		end
	end

	for (genvar s = 1; s <= W; s++) begin : g_dly
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s3[s] <= 1'b0;
			end else if (en) begin
				v_s3[s] <= v_s3[s-1];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				flg_s3[s] <= flg_s3[s-1];
				re_s3[s]  <= re_s3[s-1];
				im_s3[s]  <= im_s3[s-1];
			end
		end
	end

	// quotient sign and saturation, result select
	always_comb begin
		fl  = flg_s3[W];
		sre = ovf_re || (fl.neg_re ? (q_re[W-1] && (|q_re[W-2:0])) : q_re[W-1]);
		sim = ovf_im || (fl.neg_im ? (q_im[W-1] && (|q_im[W-2:0])) : q_im[W-1]);
		dre = sre ? {fl.neg_re, {(W-1){~fl.neg_re}}} : (fl.neg_re ? -q_re : q_re);
		dim = sim ? {fl.neg_im, {(W-1){~fl.neg_im}}} : (fl.neg_im ? -q_im : q_im);
		unique case (mode_t'(fl.mode))
			MODE_DIV: begin
				fre = fl.dz ? '0 : dre;
				fim = fl.dz ? '0 : dim;
				st  = fl.dz ? ST_DIV0 : ((sre || sim) ? ST_SAT : ST_OK);
			end
			MODE_ADD, MODE_SUB, MODE_MUL: begin
				fre = re_s3[W];
				fim = im_s3[W];
				st  = fl.sat ? ST_SAT : ST_OK;
			end
			default: begin
				fre = '0;
				fim = '0;
				st  = ST_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_re_s4 <= fre;
			res_im_s4 <= fim;
			eq_s4     <= fl.eq;
			st_s4     <= st;
		end
	end

	assign m_tdata = OUT_W'({st_s4, eq_s4, res_im_s4, res_re_s4});

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (st_s4 == ST_OK || st_s4 == ST_SAT || st_s4 == ST_DIV0))
		else $error("status code out of range");

	a_eq_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && eq_s4) |-> (res_re_s4 == '0 && res_im_s4 == '0 && st_s4 == ST_OK))
		else $error("equality word carries a result");

	a_div0_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && st_s4 == ST_DIV0) |-> (res_re_s4 == '0 && res_im_s4 == '0 && !eq_s4))
		else $error("divide-by-zero word carries a result");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!en && v_s3[W]) |=> v_s3[W])
		else $error("divider output lost during stall");

endmodule

/* verif/testbench.sv */
// Self-checking testbench for complex_arithmetic_unit: a directed table, then random words.
// Expected results come from the table or from a behavioural predictor and are checked in order of acceptance.
// Depends on rtl/cau_pkg.sv and rtl/complex_arithmetic_unit.sv.
`timescale 1ns / 100ps
module testbench;
	import cau_pkg::*;

	localparam int DW = DATA_WIDTH_DEF;
	localparam int FB = FRAC_BITS_DEF;
	localparam int IN_W = 72;
	localparam int OUT_W = 40;
	localparam int LATENCY = DW + 4;
	localparam int N_RANDOM = 880;
	localparam longint CYCLE_LIMIT = 400000;
	localparam logic [2:0] MODE_SPARE = 3'd5;
	localparam logic [2:0] MODE_SPARE_HI = 3'd7;
	localparam logic signed [15:0] QMAX = 16'sh7fff;
	localparam logic signed [15:0] QMIN = -16'sh8000;

	typedef struct {
		logic [2:0]         mode;
		logic signed [15:0] ar, ai, br, bi;
	} operands_t;

	typedef struct {
		logic signed [15:0] re, im;
		logic               eq;
		status_t            st;
	} cplx_res_t;

	typedef struct {
		operands_t ops;
		bit        known;
		cplx_res_t res;
	} vector_t;

	localparam int N_DIRECTED = 22;
	vector_t directed [N_DIRECTED] = '{
		'{'{MODE_EQ, 16'sd100, -16'sd5, 16'sd100, -16'sd5}, 1, '{16'sd0, 16'sd0, 1'b1, ST_OK}},
		'{'{MODE_EQ, 16'sd100, -16'sd5, 16'sd100, 16'sd5}, 1, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_EQ, QMIN, QMAX, QMIN, QMAX}, 1, '{16'sd0, 16'sd0, 1'b1, ST_OK}},
		'{'{MODE_ADD, QMAX, 16'sd0, 16'sd1, 16'sd0}, 1, '{QMAX, 16'sd0, 1'b0, ST_SAT}},
		'{'{MODE_ADD, QMIN, QMIN, QMIN, QMIN}, 1, '{QMIN, QMIN, 1'b0, ST_SAT}},
		'{'{MODE_ADD, 16'sd300, -16'sd7, -16'sd100, 16'sd7}, 1, '{16'sd200, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_SUB, QMIN, 16'sd0, 16'sd1, 16'sd0}, 1, '{QMIN, 16'sd0, 1'b0, ST_SAT}},
		'{'{MODE_SUB, QMAX, QMAX, QMIN, QMIN}, 1, '{QMAX, QMAX, 1'b0, ST_SAT}},
		'{'{MODE_SUB, 16'sd5, 16'sd5, 16'sd5, 16'sd5}, 1, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0}, 1, '{16'sd256, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_MUL, QMIN, QMIN, QMIN, QMIN}, 0, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_MUL, QMAX, QMIN, QMAX, QMAX}, 0, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_MUL, -16'sd1, 16'sd0, 16'sd1, 16'sd0}, 0, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_MUL, 16'sd3, -16'sd9, -16'sd200, 16'sd77}, 0, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_DIV, 16'sd500, -16'sd3, 16'sd0, 16'sd0}, 1, '{16'sd0, 16'sd0, 1'b0, ST_DIV0}},
		'{'{MODE_DIV, 16'sd256, 16'sd0, 16'sd256, 16'sd0}, 1, '{16'sd256, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_DIV, QMAX, QMAX, 16'sd1, 16'sd0}, 0, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_DIV, QMIN, QMIN, QMIN, QMIN}, 0, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_DIV, -16'sd1, 16'sd1, QMAX, QMIN}, 0, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_DIV, 16'sd1000, -16'sd77, -16'sd3, 16'sd5}, 0, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_SPARE, 16'sd1, 16'sd1, 16'sd1, 16'sd1}, 1, '{16'sd0, 16'sd0, 1'b0, ST_OK}},
		'{'{MODE_SPARE_HI, QMAX, QMIN, QMAX, QMIN}, 1, '{16'sd0, 16'sd0, 1'b0, ST_OK}}
	};

	logic             clk;
	logic             arst_n;
	logic             s_tvalid;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata;
	logic             m_tvalid;
	logic             m_tready;
	logic [OUT_W-1:0] m_tdata;

	cplx_res_t pending_results[$];
	int        n_accepted;
	int        n_mismatch;
	longint    n_cycles;
	bit        rx_hold;

	complex_arithmetic_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [15:0] clamp16(longint v, inout bit clipped);
		if (v > longint'(QMAX)) begin
			clipped = 1'b1;
			return QMAX;
		end
		if (v < longint'(QMIN)) begin
			clipped = 1'b1;
			return QMIN;
		end
		return v[15:0];
	endfunction

	// quotient of num * 2^FB by den, truncated toward zero
	function automatic longint scaled_quot(longint num, longint den);
		longint mag;
		mag = num < 0 ? -num : num;
		mag = (mag <<< FB) / den;
		return num < 0 ? -mag : mag;
	endfunction

	function automatic cplx_res_t complex_op(operands_t o);
		cplx_res_t r;
		longint ar, ai, br, bi, den;
		bit clipped;
		ar = o.ar;
		ai = o.ai;
		br = o.br;
		bi = o.bi;
		clipped = 1'b0;
		r = '{16'sd0, 16'sd0, 1'b0, ST_OK};
		case (o.mode)
			MODE_EQ: r.eq = (ar == br) && (ai == bi);
			MODE_ADD: begin
				r.re = clamp16(ar + br, clipped);
				r.im = clamp16(ai + bi, clipped);
			end
			MODE_SUB: begin
				r.re = clamp16(ar - br, clipped);
				r.im = clamp16(ai - bi, clipped);
			end
			MODE_MUL: begin
				r.re = clamp16((ar * br - ai * bi) >>> FB, clipped);
				r.im = clamp16((ai * br + ar * bi) >>> FB, clipped);
			end
			MODE_DIV: begin
				den = br * br + bi * bi;
				if (den == 0)
					r.st = ST_DIV0;
				else begin
					r.re = clamp16(scaled_quot(ar * br + ai * bi, den), clipped);
					r.im = clamp16(scaled_quot(ai * br - ar * bi, den), clipped);
				end
			end
			default: ;
		endcase
		if (clipped && r.st == ST_OK)
			r.st = ST_SAT;
		return r;
	endfunction

	function automatic logic signed [15:0] rand_part();
		case ($urandom_range(0, 5))
			0: return QMAX;
			1: return QMIN;
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			3: return 16'($signed($urandom_range(0, 16)) - 8);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic operands_t rand_operands();
		operands_t o;
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 15)
			o.mode = MODE_EQ;
		else if (pick < 32)
			o.mode = MODE_ADD;
		else if (pick < 49)
			o.mode = MODE_SUB;
		else if (pick < 70)
			o.mode = MODE_MUL;
		else if (pick < 94)
			o.mode = MODE_DIV;
		else
			o.mode = 3'($urandom_range(MODE_SPARE, MODE_SPARE_HI));
		o.ar = rand_part();
		o.ai = rand_part();
		o.br = rand_part();
		o.bi = rand_part();
		if (o.mode == MODE_EQ && $urandom_range(0, 1)) begin
			o.br = o.ar;
			o.bi = $urandom_range(0, 2) ? o.ai : o.ai ^ (16'd1 << $urandom_range(0, 15));
		end
		if (o.mode == MODE_DIV && $urandom_range(0, 9) == 0) begin
			o.br = 16'sd0;
			o.bi = 16'sd0;
		end
		return o;
	endfunction

	task automatic send_word(operands_t o, bit known, cplx_res_t typed);
		s_tvalid <= 1'b1;
		s_tdata  <= {5'd0, o.bi, o.br, o.ai, o.ar, o.mode};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		pending_results.push_back(known ? typed : complex_op(o));
		n_accepted++;
	endtask

	task automatic maybe_gap(inout int burst_left);
		int gap;
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 8);
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	initial begin
		int burst_left;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		burst_left = 0;
		n_accepted = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed[i]) begin
			send_word(directed[i].ops, directed[i].known, directed[i].res);
			maybe_gap(burst_left);
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		for (int i = 0; i < N_RANDOM; i++) begin
			send_word(rand_operands(), 1'b0, '{16'sd0, 16'sd0, 1'b0, ST_OK});
			if (!rx_hold)
				maybe_gap(burst_left);
		end
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (2 * LATENCY) @(posedge clk);
		if (n_mismatch == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// long receiver hold-off while the sender keeps offering
	initial begin
		rx_hold = 1'b0;
		wait (n_accepted >= 300);
		@(posedge clk);
		rx_hold = 1'b1;
		repeat (150) @(posedge clk);
		rx_hold = 1'b0;
	end

	initial begin
		int phase;
		m_tready = 1'b0;
		phase = 0;
		forever begin
			@(posedge clk);
			phase = (phase + 1) % 64;
			if (rx_hold)
				m_tready <= 1'b0;
			else if (phase < 20)
				m_tready <= 1'b1;
			else
				m_tready <= $urandom_range(0, 3) != 0;
		end
	end

	always @(posedge clk) begin
		cplx_res_t want;
		cplx_res_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.re = m_tdata[15:0];
			got.im = m_tdata[31:16];
			got.eq = m_tdata[32];
			got.st = status_t'(m_tdata[34:33]);
			if (pending_results.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected word: re %0d im %0d eq %0b st %0d",
						got.re, got.im, got.eq, got.st);
			end else begin
				want = pending_results.pop_front();
				if (got.re !== want.re || got.im !== want.im || got.eq !== want.eq
						|| got.st !== want.st || m_tdata[39:35] !== 5'd0) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display({"mismatch: exp re %0d im %0d eq %0b st %0d,",
							" got re %0d im %0d eq %0b st %0d"},
							want.re, want.im, want.eq, want.st,
							got.re, got.im, got.eq, got.st);
				end
			end
		end
	end

	initial begin
		n_mismatch = 0;
		n_cycles = 0;
		forever begin
			@(posedge clk);
			n_cycles++;
			if (n_cycles > CYCLE_LIMIT) begin
				$display("FAIL");
				$finish;
			end
		end
	end

endmodule
